@@ rtl/core/csg_pkg.sv @@
// ----------------------------------------------------------------------------
// csg_pkg: shared types and constants for the circle span generator
// Coordinate, error and state encodings used by the span sequencer.
// ----------------------------------------------------------------------------
package csg_pkg;

    // Screen coordinates, wide enough for 2*center - position up to 2048
    localparam int CRD_W = 12;
    // Signed offset of the walk position from the centre
    localparam int OFS_W = 7;
    // Signed squared-distance error terms
    localparam int ERR_W = 14;

    typedef logic [CRD_W-1:0]        t_crd;
    typedef logic signed [OFS_W-1:0] t_ofs;
    typedef logic signed [ERR_W-1:0] t_err;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIAM  = 5'b00010,
        S_UPPER = 5'b00100,
        S_LOWER = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    // One clipped span from the clip unit
    typedef struct packed {
        logic       keep;
        logic [9:0] row;
        logic [9:0] start;
        logic [9:0] length;
    } t_span;

endpackage

@@ rtl/core/circle_span_generator.sv @@
// ----------------------------------------------------------------------------
// circle_span_generator: filled circle to horizontal span converter
// Walks the upper-left quarter arc of one circle and emits clipped spans.
// ----------------------------------------------------------------------------
// Usage:
//   Present a circle on i_center_x, i_center_y, i_radius and raise start; the
//   item is taken at a clock edge where start is high and busy is low. busy
//   drops in the cycle in which the last span of the circle is on the outputs.
//   Each result appears on the o_ ports for exactly one cycle with o_strobe
//   high; o_last_span marks the final result of the circle. The receiver
//   cannot stall, so nothing is held back.
//   A rejected circle (off screen or radius above MAX_RADIUS) gives one
//   result with o_status high the cycle after it is taken, and busy stays low.
//   An accepted circle keeps busy high through the diameter span, an upper
//   and a lower step per arc move (one shared move/error unit picks the move,
//   one shared clip unit clips the upper and then the lower span), and a
//   flush of the held span; a new circle is taken only once it is done. One
//   span is held back so the last one can be marked.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
//   any circle in progress.
module circle_span_generator
    import csg_pkg::*;
#(
    parameter int SCREEN_W   = 240,
    parameter int SCREEN_H   = 320,
    parameter int MAX_RADIUS = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [9:0] i_center_x,
    input  logic [9:0] i_center_y,
    input  logic [4:0] i_radius,
    output logic       o_strobe,
    output logic       o_status,
    output logic [9:0] o_span_row,
    output logic [9:0] o_span_start,
    output logic [9:0] o_span_length,
    output logic       o_last_span
);

    localparam int   STEP_W   = $clog2(2 * MAX_RADIUS + 1);
    localparam t_crd W_L      = t_crd'(SCREEN_W);
    localparam t_crd H_L      = t_crd'(SCREEN_H);
    localparam t_crd W_M1     = t_crd'(SCREEN_W - 1);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(2 * MAX_RADIUS);
    localparam logic [4:0] RAD_MAX = 5'(MAX_RADIUS);

    // Sequencer and walk state
    t_state            r_state, n_state;
    t_crd              r_cx, r_cy, r_px, r_py;
    t_crd              n_px, n_py;
    t_ofs              r_dx, r_dy, n_dx, n_dy;
    logic [4:0]        r_rad;
    logic [9:0]        r_rr;
    logic [STEP_W-1:0] r_steps, n_steps;

    // Held span and output registers
    logic       r_pend_vld, n_pend_vld;
    t_span      r_pend, n_pend;
    logic       r_strobe, n_strobe;
    logic       r_status, n_status;
    logic [9:0] r_row, n_row, r_start, n_start, r_len, n_len;
    logic       r_last, n_last;

    // Input checks
    logic       accept;
    logic       reject;
    t_crd       in_cx, in_cy, in_r;
    logic [9:0] in_rr;

    assign accept = start && (r_state == S_IDLE);
    assign in_cx  = t_crd'(i_center_x);
    assign in_cy  = t_crd'(i_center_y);
    assign in_r   = t_crd'(i_radius);
    assign in_rr  = 10'(i_radius * i_radius);
    assign reject = (in_cx + in_r > W_L) || (in_cx < in_r) ||
                    (in_cy + in_r > H_L) || (in_cy < in_r) || (i_radius > RAD_MAX);

    // Shared move unit: squared-distance errors of the three candidate moves
    t_err dxe, dye, dx1, dy1, rre;
    t_err sq_dx, sq_dx1, sq_dy, sq_dy1;
    t_err d_right, d_up, d_diag, e_right, e_up, e_diag;
    logic mv_right, mv_up;
    logic walk_done;

    assign dxe    = t_err'(r_dx);
    assign dye    = t_err'(r_dy);
    assign dx1    = dxe + t_err'(1);
    assign dy1    = dye - t_err'(1);
    assign rre    = t_err'(r_rr);
    assign sq_dx  = dxe * dxe;
    assign sq_dx1 = dx1 * dx1;
    assign sq_dy  = dye * dye;
    assign sq_dy1 = dy1 * dy1;

    assign d_right = sq_dx1 + sq_dy - rre;
    assign d_up    = sq_dy1 + sq_dx - rre;
    assign d_diag  = sq_dy1 + sq_dx1 - rre;
    assign e_right = d_right[ERR_W-1] ? -d_right : d_right;
    assign e_up    = d_up[ERR_W-1] ? -d_up : d_up;
    assign e_diag  = d_diag[ERR_W-1] ? -d_diag : d_diag;

    // Pick the move; ties with the diagonal fall to the diagonal, a right/up tie to up
    always_comb begin
        if (e_right < e_up) begin
            mv_right = 1'b1;
            mv_up    = !(e_right < e_diag);
        end else begin
            mv_right = !(e_up < e_diag);
            mv_up    = 1'b1;
        end
    end

    // Stop at the top point or after the move budget
    assign walk_done = ((r_dx == t_ofs'(0)) && (r_dy == -t_ofs'(r_rad))) ||
                       (r_steps == STEP_MAX);

    // Shared clip unit: select the span for this state, clip it to the screen
    t_crd  sp_row, sp_end, sp_endc, mir_x, mir_y;
    t_span clip;

    assign mir_x = {r_cx[CRD_W-2:0], 1'b0} - r_px;
    assign mir_y = {r_cy[CRD_W-2:0], 1'b0} - r_py;

    always_comb begin
        case (r_state)
            S_DIAM: begin
                sp_row = r_py;
                sp_end = r_cx + t_crd'(r_rad);
            end
            S_LOWER: begin
                sp_row = mir_y;
                sp_end = mir_x;
            end
            default: begin
                sp_row = r_py;
                sp_end = mir_x;
            end
        endcase
    end

    always_comb begin
        sp_endc     = (sp_end > W_M1) ? W_M1 : sp_end;
        clip.keep   = (r_state inside {S_DIAM, S_UPPER, S_LOWER}) &&
                      (sp_row < H_L) && (r_px < W_L);
        clip.row    = sp_row[9:0];
        clip.start  = r_px[9:0];
        clip.length = (sp_endc >= r_px) ? 10'(sp_endc - r_px) : 10'd0;
    end

    // Sequencer and output selection
    always_comb begin
        n_state    = r_state;
        n_px       = r_px;
        n_py       = r_py;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_steps    = r_steps;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_strobe   = 1'b0;
        n_status   = 1'b0;
        n_row      = r_pend.row;
        n_start    = r_pend.start;
        n_len      = r_pend.length;
        n_last     = 1'b0;

        // Emit the held span when a new one takes its place
        if (clip.keep) begin
            n_strobe   = r_pend_vld;
            n_pend     = clip;
            n_pend_vld = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (reject) begin
                        n_strobe = 1'b1;
                        n_status = 1'b1;
                        n_row    = '0;
                        n_start  = '0;
                        n_len    = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_state    = S_DIAM;
                        n_px       = in_cx - in_r;
                        n_py       = in_cy;
                        n_dx       = -t_ofs'(i_radius);
                        n_dy       = '0;
                        n_steps    = '0;
                        n_pend_vld = 1'b0;
                    end
                end
            end
            S_DIAM, S_LOWER: begin
                if (walk_done) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_UPPER;
                    n_steps = r_steps + STEP_W'(1);
                    if (mv_right) begin
                        n_px = r_px + t_crd'(1);
                        n_dx = r_dx + t_ofs'(1);
                    end
                    if (mv_up) begin
                        n_py = r_py - t_crd'(1);
                        n_dy = r_dy - t_ofs'(1);
                    end
                end
            end
            S_UPPER: begin
                n_state = S_LOWER;
            end
            S_FLUSH: begin
                // Send the held span as last, or an empty result if none
                n_state    = S_IDLE;
                n_strobe   = 1'b1;
                n_last     = 1'b1;
                n_pend_vld = 1'b0;
                if (!r_pend_vld) begin
                    n_row   = '0;
                    n_start = '0;
                    n_len   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx  <= in_cx;
            r_cy  <= in_cy;
            r_rad <= i_radius;
            r_rr  <= in_rr;
        end
        r_px    <= n_px;
        r_py    <= n_py;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_steps <= n_steps;
        r_pend  <= n_pend;
        r_status <= n_status;
        r_row   <= n_row;
        r_start <= n_start;
        r_len   <= n_len;
        r_last  <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_span_row    = r_row;
    assign o_span_start  = r_start;
    assign o_span_length = r_len;
    assign o_last_span   = r_last;

endmodule

@@ verif/tb_circle_span_generator.sv @@
// ----------------------------------------------------------------------------
// tb_circle_span_generator: self-checking bench for the circle span generator
// Feeds directed and random circles through the start/busy handshake, predicts
// the clipped span list of each accepted circle and checks every strobed
// result in order against it. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_circle_span_generator;
    import csg_pkg::*;

    localparam int SCREEN_W     = 240;
    localparam int SCREEN_H     = 320;
    localparam int MAX_RADIUS   = 15;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_ITEMS  = 47;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 200000;

    // One span result as seen on the output ports
    typedef struct packed {
        logic       status;
        logic [9:0] row;
        logic [9:0] first;
        logic [9:0] length;
        logic       last;
    } t_result;

    // One circle item
    typedef struct packed {
        logic [9:0] cx;
        logic [9:0] cy;
        logic [4:0] r;
    } t_circle;

    // Predicts the span list of each accepted circle and checks results in order
    class circle_span_scoreboard;
        t_result expected_spans[$];
        t_result circle_spans[$];
        int      error_count = 0;

        // Clip one span to the screen and append it to the current circle
        function void clip_span(int row, int first, int last_col);
            t_result s;
            int      len;
            if (row < 0 || row >= SCREEN_H || last_col < 0 || first >= SCREEN_W)
                return;
            if (last_col >= SCREEN_W)
                last_col = SCREEN_W - 1;
            if (first < 0)
                first = 0;
            len = last_col - first;
            if (len < 0)
                len = 0;
            s.status = 1'b0;
            s.row    = row[9:0];
            s.first  = first[9:0];
            s.length = len[9:0];
            s.last   = 1'b0;
            circle_spans.push_back(s);
        endfunction

        // Work out every span of an accepted circle item
        function void note_circle(t_circle c);
            int      cx, cy, r, rr, px, py, endx, endy, steps, dx, dy;
            int      e_right, e_up, e_diag;
            t_result s;
            cx = int'(c.cx);
            cy = int'(c.cy);
            r  = int'(c.r);
            circle_spans.delete();
            s = '0;
            if (cx > SCREEN_W - r || cx < r || cy > SCREEN_H - r || cy < r
                    || r > MAX_RADIUS) begin
                s.status = 1'b1;
                s.last   = 1'b1;
                expected_spans.push_back(s);
                return;
            end
            rr    = r * r;
            px    = cx - r;
            py    = cy;
            endx  = cx;
            endy  = cy - r;
            steps = 0;
            clip_span(py, px, cx + r);
            // Walk the upper-left arc, picking the move closest to the circle
            while (!(px == endx && py == endy) && steps < 2 * MAX_RADIUS) begin
                dx      = px - cx;
                dy      = py - cy;
                e_right = (dx + 1) * (dx + 1) + dy * dy - rr;
                e_up    = (dy - 1) * (dy - 1) + dx * dx - rr;
                e_diag  = (dy - 1) * (dy - 1) + (dx + 1) * (dx + 1) - rr;
                if (e_right < 0) e_right = -e_right;
                if (e_up < 0)    e_up    = -e_up;
                if (e_diag < 0)  e_diag  = -e_diag;
                if (e_right < e_up && e_right < e_diag) begin
                    px++;
                end else if (e_right >= e_up && e_up < e_diag) begin
                    py--;
                end else begin
                    px++;
                    py--;
                end
                steps++;
                clip_span(py, px, 2 * cx - px);
                clip_span(2 * cy - py, px, 2 * cx - px);
            end
            // A circle clipped away entirely still gives one marked result
            if (circle_spans.size() == 0) begin
                s.last = 1'b1;
                circle_spans.push_back(s);
            end else begin
                circle_spans[circle_spans.size() - 1].last = 1'b1;
            end
            foreach (circle_spans[i])
                expected_spans.push_back(circle_spans[i]);
        endfunction

        function void compare_field(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
                error_count++;
            end
        endfunction

        // Check one strobed result against the oldest expectation
        function void check_span(t_result got);
            t_result exp_s;
            if (expected_spans.size() == 0) begin
                $display("%0t: unexpected span, expected none, actual row %0d start %0d",
                         $time, got.row, got.first);
                error_count++;
                return;
            end
            exp_s = expected_spans.pop_front();
            compare_field("status", int'(exp_s.status), int'(got.status));
            compare_field("span_row", int'(exp_s.row), int'(got.row));
            compare_field("span_start", int'(exp_s.first), int'(got.first));
            compare_field("span_length", int'(exp_s.length), int'(got.length));
            compare_field("last_span", int'(exp_s.last), int'(got.last));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [9:0] i_center_x = '0;
    logic [9:0] i_center_y = '0;
    logic [4:0] i_radius = '0;
    logic       o_strobe;
    logic       o_status;
    logic [9:0] o_span_row;
    logic [9:0] o_span_start;
    logic [9:0] o_span_length;
    logic       o_last_span;

    circle_span_scoreboard span_sb = new();
    int unsigned cycle_count = 0;

    circle_span_generator #(
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H),
        .MAX_RADIUS (MAX_RADIUS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_span_row    (o_span_row),
        .o_span_start  (o_span_start),
        .o_span_length (o_span_length),
        .o_last_span   (o_last_span)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check each strobed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            span_sb.check_span({o_status, o_span_row, o_span_start, o_span_length,
                                o_last_span});
    end

    // Present one circle and hold it until taken
    task automatic drive_circle(t_circle c);
        start      <= 1'b1;
        i_center_x <= c.cx;
        i_center_y <= c.cy;
        i_radius   <= c.r;
        do @(posedge i_clk); while (busy);
        span_sb.note_circle(c);
    endtask

    // With idle_pct percent chance, drop start for a random gap, short or long
    task automatic rest_sender(int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                              : $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Favor the edges of a coordinate range
    function automatic int pick_coord(int lo, int hi);
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return lo;
        if (sel == 1) return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Mostly on-screen circles, some just off screen or too large, some noise
    function automatic t_circle random_circle();
        t_circle c;
        int      pick, r, side;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            r    = $urandom_range(0, MAX_RADIUS);
            c.r  = 5'(r);
            c.cx = 10'(pick_coord(r, SCREEN_W - r));
            c.cy = 10'(pick_coord(r, SCREEN_H - r));
        end else if (pick < 88) begin
            r    = $urandom_range(1, MAX_RADIUS);
            side = $urandom_range(0, 4);
            c.r  = 5'(r);
            c.cx = 10'($urandom_range(r, SCREEN_W - r));
            c.cy = 10'($urandom_range(r, SCREEN_H - r));
            case (side)
                0: c.cx = 10'(r - 1);
                1: c.cx = 10'(SCREEN_W - r + 1);
                2: c.cy = 10'(r - 1);
                3: c.cy = 10'(SCREEN_H - r + 1);
                default: c.r = 5'($urandom_range(MAX_RADIUS + 1, 31));
            endcase
        end else begin
            c.cx = 10'($urandom_range(0, 1023));
            c.cy = 10'($urandom_range(0, 1023));
            c.r  = 5'($urandom_range(0, 31));
        end
        return c;
    endfunction

    initial begin
        t_circle directed[$];
        int      phase_idle[4];
        phase_idle = '{0, 63, 0, 24};
        // Center, small and largest radius, too large, zero radius, corners, edges, off screen
        directed = '{
            '{10'd120, 10'd160, 5'd0},  '{10'd120, 10'd160, 5'd1},
            '{10'd120, 10'd160, 5'd2},  '{10'd120, 10'd160, 5'd3},
            '{10'd120, 10'd160, 5'd5},  '{10'd120, 10'd160, 5'd15},
            '{10'd120, 10'd160, 5'd16}, '{10'd120, 10'd160, 5'd31},
            '{10'd0,   10'd0,   5'd0},  '{10'd240, 10'd160, 5'd0},
            '{10'd120, 10'd320, 5'd0},  '{10'd240, 10'd320, 5'd0},
            '{10'd15,  10'd15,  5'd15}, '{10'd225, 10'd305, 5'd15},
            '{10'd14,  10'd160, 5'd15}, '{10'd226, 10'd160, 5'd15},
            '{10'd120, 10'd14,  5'd15}, '{10'd120, 10'd306, 5'd15},
            '{10'd0,   10'd160, 5'd1},  '{10'd240, 10'd160, 5'd5},
            '{10'd1023, 10'd1023, 5'd31}, '{10'd1023, 10'd0, 5'd0}
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items back to back
        foreach (directed[i])
            drive_circle(directed[i]);

        // Random items, one sender gap setting per phase
        foreach (phase_idle[p]) begin
            repeat (PHASE_ITEMS) begin
                drive_circle(random_circle());
                rest_sender(phase_idle[p]);
            end
        end
        start <= 1'b0;

        // Drain outstanding spans, then watch for stray results
        while (span_sb.expected_spans.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (span_sb.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/csg_pkg.sv
rtl/core/circle_span_generator.sv
verif/tb_circle_span_generator.sv
